>>> sv/pct_pkg.sv
// ---------------------------------------------------------------------------
// pct_pkg: shared types and codes for the pulldown cadence tracker
// Class codes, register indexes, classifier result struct and helpers.
// ---------------------------------------------------------------------------
package pct_pkg;

  localparam int FLAG_W  = 10;
  localparam int CODE_W  = 4;
  localparam int CNT_W   = 8;
  localparam int START_W = 24;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int NUM_PHASES  = 5;

  // Class codes: 0..4 pulldown phase
  localparam logic [CODE_W-1:0] CODE_NONE = 4'd5;
  localparam logic [CODE_W-1:0] CODE_BOB  = 4'd6;
  localparam logic [CODE_W-1:0] CODE_DINT = 4'd7;
  localparam logic [CODE_W-1:0] CODE_UNK  = 4'd8;

  // Fixed comb patterns
  localparam logic [FLAG_W-1:0] PAT_ALT_ODD  = 10'h2AA;
  localparam logic [FLAG_W-1:0] PAT_ALT_EVEN = 10'h155;
  localparam logic [FLAG_W-1:0] PAT_ALL      = 10'h3FF;
  localparam logic [5:0]        PAT_ALT_HEAD = 6'h2A;

  typedef enum logic [1:0] {
    REG_SEQ_THRESHOLD = 2'd0,
    REG_COMB_RUN_LEN  = 2'd1,
    REG_PAIR_EXTRA    = 2'd2,
    REG_PAIR_MIN      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] block_class;
    logic [CODE_W-1:0] cand_low;
    logic [CODE_W-1:0] cand_high;
  } class_result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> sv/pct_classify.sv
// ---------------------------------------------------------------------------
// pct_classify: block classifier
// Maps ten comb flags to a raw class and a candidate phase pair.
// ---------------------------------------------------------------------------
module pct_classify
  import pct_pkg::*;
(
  input  logic [FLAG_W-1:0] comb_flags,
  input  logic [3:0]        comb_run_length,
  output class_result_t     result
);

  logic [15:0] have_run;
  logic        long_run;
  logic        e0, e1, e2, e3, e4;

  // have_run[l]: some window of l consecutive combed fields exists
  always_comb begin
    have_run    = '0;
    have_run[0] = 1'b1;
    for (int l = 1; l <= FLAG_W; l++) begin
      for (int s = 0; s + l <= FLAG_W; s++) begin
        if (((comb_flags >> s) & FLAG_W'((1 << l) - 1)) == FLAG_W'((1 << l) - 1)) begin
          have_run[l] = 1'b1;
        end
      end
    end
  end

  assign long_run = have_run[comb_run_length];

  // Fold the two frames of each phase slot together
  assign e0 = comb_flags[0] | comb_flags[5];
  assign e1 = comb_flags[1] | comb_flags[6];
  assign e2 = comb_flags[2] | comb_flags[7];
  assign e3 = comb_flags[3] | comb_flags[8];
  assign e4 = comb_flags[4] | comb_flags[9];

  always_comb begin
    result.block_class = CODE_UNK;
    result.cand_low    = CODE_UNK;
    result.cand_high   = CODE_UNK;
    if (comb_flags == '0) begin
      result = '{CODE_NONE, CODE_NONE, CODE_NONE};
    end else if (comb_flags == PAT_ALL) begin
      result = '{CODE_BOB, CODE_BOB, CODE_BOB};
    end else if (comb_flags == PAT_ALT_ODD || comb_flags == PAT_ALT_EVEN ||
                 comb_flags[5:0] == PAT_ALT_HEAD) begin
      result = '{CODE_DINT, CODE_DINT, CODE_DINT};
    end else if (e0) begin
      result.cand_low  = 4'd3;
      result.cand_high = 4'd4;
      if (e2) result.block_class = 4'd4;
      else if (e3) result.block_class = 4'd3;
    end else if (e1) begin
      result.cand_low  = 4'd1;
      result.cand_high = 4'd2;
      if (e3) result.block_class = 4'd2;
      else if (e4) result.block_class = 4'd1;
    end else if (e2) begin
      result.cand_low  = 4'd0;
      result.cand_high = 4'd4;
      if (e4) result.block_class = 4'd0;
    end else if (e3) begin
      result.cand_low  = 4'd2;
      result.cand_high = 4'd3;
    end else if (e4) begin
      result.cand_low  = 4'd0;
      result.cand_high = 4'd1;
    end
    // A long run of combed fields overrides everything
    if (long_run) begin
      result = '{CODE_BOB, CODE_BOB, CODE_BOB};
    end
  end

endmodule

>>> sv/pulldown_cadence_tracker_top.sv
// ---------------------------------------------------------------------------
// pulldown_cadence_tracker_top: 3:2 pulldown cadence tracker
// Classifies blocks of ten field comb flags and tracks the pulldown phase.
// ---------------------------------------------------------------------------
// The result is registered: m_tvalid rises in the cycle after an input is accepted.
// Throughput: one item per cycle while m_tready is high; the tracker update and the classifier sit
//   between the input handshake and the single result register.
// Reset (rst, synchronous): registers return to 3/3/3/2, no phase adopted,
//   all counters and votes cleared, output empty. No clearing pass is needed.
module pulldown_cadence_tracker_top
  import pct_pkg::*;
#(
  parameter int BLOCK_INDEX_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input item
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] comb_flags, rest zero
  // Result item
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] block_class,
                                            // [7:4] candidate_low,
                                            // [11:8] candidate_high,
                                            // [15:12] tracked_cadence,
                                            // [16] change_event,
                                            // [40:17] change_start_field
  // Configuration
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int BW = BLOCK_INDEX_BITS;

  // Configuration registers
  logic [CNT_W-1:0] sequence_threshold;
  logic [3:0]       comb_run_length;
  logic [CNT_W-1:0] pair_check_extra;
  logic [CNT_W-1:0] pair_min_votes;

  // Tracker state
  logic [CODE_W-1:0] adopted_phase, adopted_phase_next;
  logic [CODE_W-1:0] previous_class;
  logic [CNT_W-1:0]  agree_count, agree_count_next;
  logic              count_locked, count_locked_next;
  logic              pair_missing, pair_missing_next;
  logic [CNT_W-1:0]  pair_votes [NUM_PHASES];
  logic [CNT_W-1:0]  pair_votes_next [NUM_PHASES];
  logic [CNT_W-1:0]  voted_blocks, voted_blocks_next;
  logic              any_change_made, any_change_made_next;
  logic [BW-1:0]     candidate_start_block, candidate_start_block_next;
  logic [BW-1:0]     block_number;

  // Result register
  logic [CODE_W-1:0]  block_class, candidate_low, candidate_high, tracked_cadence;
  logic               change_event;
  logic [START_W-1:0] change_start_field;

  class_result_t      cls;
  logic               accept;
  logic               event_next;
  logic [BW-1:0]      event_block;
  logic [START_W-1:0] event_block24;
  logic [START_W-1:0] start_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pct_classify u_classify (
    .comb_flags      (s_tdata[FLAG_W-1:0]),
    .comb_run_length (comb_run_length),
    .result          (cls)
  );

  // Tracker update for one block, in the order the decisions are made
  always_comb begin
    logic [CODE_W-1:0] cur, prior, key;
    logic [CNT_W-1:0]  best;
    logic [CNT_W:0]    check_at;

    adopted_phase_next         = adopted_phase;
    agree_count_next           = agree_count;
    count_locked_next          = count_locked;
    pair_missing_next          = pair_missing;
    pair_votes_next            = pair_votes;
    voted_blocks_next          = voted_blocks;
    any_change_made_next       = any_change_made;
    candidate_start_block_next = candidate_start_block;
    event_next                 = 1'b0;
    event_block                = '0;
    key                        = '0;
    best                       = '0;

    cur      = cls.block_class;
    prior    = previous_class;
    check_at = {1'b0, sequence_threshold} + {1'b0, pair_check_extra};

    // A clean block continues whatever phase is adopted
    if (adopted_phase != CODE_UNK && cur == CODE_NONE) cur = adopted_phase;
    if (adopted_phase != CODE_UNK && prior == CODE_NONE) prior = adopted_phase;

    // Unknown block while a phase is held: match against its pair and vote
    if (adopted_phase != CODE_UNK && cur == CODE_UNK) begin
      if (adopted_phase == cls.cand_low) cur = cls.cand_low;
      if (adopted_phase == cls.cand_high) cur = cls.cand_high;
      if (adopted_phase != cls.cand_low && adopted_phase != cls.cand_high) begin
        pair_missing_next = 1'b1;
      end
      if ({1'b0, voted_blocks} >= check_at) begin
        key  = '0;
        best = pair_votes[0];
        for (int k = 1; k < NUM_PHASES; k++) begin
          if (pair_votes[k] > best) begin
            best = pair_votes[k];
            key  = CODE_W'(k);
          end
        end
        if (adopted_phase != key && best > pair_min_votes) begin
          event_next           = 1'b1;
          event_block          = candidate_start_block;
          adopted_phase_next   = key;
          cur                  = key;
          any_change_made_next = 1'b1;
        end
        for (int k = 0; k < NUM_PHASES; k++) pair_votes_next[k] = '0;
        pair_missing_next = 1'b0;
        voted_blocks_next = '0;
        agree_count_next  = '0;
        count_locked_next = 1'b1;
      end
    end

    // Leaving the locked phase: mark where a new candidate run starts
    if (adopted_phase_next != cur && count_locked_next) begin
      candidate_start_block_next = block_number;
      agree_count_next           = '0;
      count_locked_next          = 1'b0;
    end

    // Count agreeing blocks and adopt at the threshold
    if (cur != CODE_UNK && cur == prior && !count_locked_next) begin
      agree_count_next = sat_inc(agree_count_next);
      if (agree_count_next >= sequence_threshold) begin
        if (adopted_phase_next != cur && cur != CODE_NONE) begin
          adopted_phase_next = cur;
          if (!any_change_made_next) candidate_start_block_next = '0;
          event_next           = 1'b1;
          event_block          = candidate_start_block_next;
          any_change_made_next = 1'b1;
          for (int k = 0; k < NUM_PHASES; k++) pair_votes_next[k] = '0;
          pair_missing_next = 1'b0;
          voted_blocks_next = '0;
        end
        agree_count_next  = '0;
        count_locked_next = 1'b1;
      end
    end else if (!count_locked_next) begin
      agree_count_next = '0;
    end

    // Vote for the candidate pair; only phase codes get a vote
    if (pair_missing_next && cur != CODE_NONE) begin
      for (int k = 0; k < NUM_PHASES; k++) begin
        if (cls.cand_low == CODE_W'(k) || cls.cand_high == CODE_W'(k)) begin
          pair_votes_next[k] = sat_inc(pair_votes_next[k]);
        end
      end
      voted_blocks_next = sat_inc(voted_blocks_next);
    end
  end

  // Start field is block index times ten, kept to 24 bits
  assign event_block24 = START_W'(event_block);
  assign start_next    = event_next ? (event_block24 << 3) + (event_block24 << 1) : '0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_threshold <= 8'd3;
      comb_run_length    <= 4'd3;
      pair_check_extra   <= 8'd3;
      pair_min_votes     <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEQ_THRESHOLD: sequence_threshold <= cfg_data;
        REG_COMB_RUN_LEN:  comb_run_length    <= cfg_data[3:0];
        REG_PAIR_EXTRA:    pair_check_extra   <= cfg_data;
        REG_PAIR_MIN:      pair_min_votes     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tracker state: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      adopted_phase         <= CODE_UNK;
      previous_class        <= CODE_UNK;
      agree_count           <= '0;
      count_locked          <= 1'b0;
      pair_missing          <= 1'b0;
      for (int k = 0; k < NUM_PHASES; k++) pair_votes[k] <= '0;
      voted_blocks          <= '0;
      any_change_made       <= 1'b0;
      candidate_start_block <= '0;
      block_number          <= '0;
    end else if (accept) begin
      adopted_phase         <= adopted_phase_next;
      previous_class        <= cls.block_class;
      agree_count           <= agree_count_next;
      count_locked          <= count_locked_next;
      pair_missing          <= pair_missing_next;
      pair_votes            <= pair_votes_next;
      voted_blocks          <= voted_blocks_next;
      any_change_made       <= any_change_made_next;
      candidate_start_block <= candidate_start_block_next;
      block_number          <= block_number + 1'b1;
    end
  end

  // Result register: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      block_class        <= cls.block_class;
      candidate_low      <= cls.cand_low;
      candidate_high     <= cls.cand_high;
      tracked_cadence    <= adopted_phase_next;
      change_event       <= event_next;
      change_start_field <= start_next;
    end
  end

  assign m_tdata = {7'd0, change_start_field, change_event, tracked_cadence,
                    candidate_high, candidate_low, block_class};

  // Checks
  a_event_has_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && change_event) |->
      (tracked_cadence != CODE_UNK && tracked_cadence != CODE_NONE))
    else $error("change event without an adopted phase");

  a_quiet_start_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !change_event) |-> (change_start_field == '0))
    else $error("start field set without a change event");

  a_adopted_legal: assert property (@(posedge clk) disable iff (rst)
    (adopted_phase <= CODE_UNK) && (adopted_phase != CODE_NONE))
    else $error("adopted phase holds an illegal code");

  a_votes_need_miss: assert property (@(posedge clk) disable iff (rst)
    !pair_missing |-> (voted_blocks == '0))
    else $error("voted blocks counted without a pair miss");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule
